// ===== hdl/mpd_pkg.sv =====
// Shared types, constants and helpers for the mesh packet deframer.
// No dependencies; every other file in hdl/ refers to this package.
package mpd_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  // frame byte count saturates at MAX_FRAME_BYTES + 1
  localparam int FC_W = $clog2(MAX_FRAME_BYTES + 2);

  localparam int MAX_RESULTS = 3;
  localparam int RQ_DEPTH    = 4;
  localparam int RQ_AW       = $clog2(RQ_DEPTH);

  localparam logic [9:0] ADVERT_FULL_LEN = 10'd107;
  localparam logic [9:0] ADVERT_TRIM_LEN = 10'd106;
  localparam logic [8:0] PAYLOAD_SAT     = 9'd511;

  // record kinds
  localparam logic [2:0] KIND_HDR     = 3'd0;
  localparam logic [2:0] KIND_XPORT   = 3'd1;
  localparam logic [2:0] KIND_PATHLEN = 3'd2;
  localparam logic [2:0] KIND_PATH    = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_XPORT_MASK = 2'd0;
  localparam logic [1:0] CFG_MAX_PATH   = 2'd1;
  localparam logic [1:0] CFG_MAX_PAY    = 2'd2;
  localparam logic [1:0] CFG_ADVERT     = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic [1:0]  route_code;
    logic [3:0]  pay_code;
    logic [1:0]  version;
    logic        status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [3:0] transport_route_mask;
    logic [7:0] max_path_len;
    logic [8:0] max_payload_len;
    logic [3:0] advert_type_code;
  } cfg_t;

  // records produced by one input item, first cnt entries valid
  typedef struct packed {
    logic [1:0]                 cnt;
    out_t [MAX_RESULTS-1:0]     rec;
  } res_t;

  function automatic out_t mk_rec(logic [2:0] kind, logic [15:0] value, logic status,
                                  logic last, logic [7:0] hdr);
    out_t r;
    r.kind       = kind;
    r.value      = value;
    r.route_code = hdr[1:0];
    r.pay_code   = hdr[5:2];
    r.version    = hdr[7:6];
    r.status     = status;
    r.last       = last;
    return r;
  endfunction

endpackage

// ===== hdl/mpd_step.sv =====
// Per-byte deframing logic: frame state registers and the record builder.
// Depends on mpd_pkg.
module mpd_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  mpd_pkg::in_t  item,
  input  mpd_pkg::cfg_t cfg,
  output mpd_pkg::res_t res
);

  localparam int FCW = mpd_pkg::FC_W;
  localparam logic [FCW-1:0] FC_MAX = FCW'(mpd_pkg::MAX_FRAME_BYTES);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_XPORT   = 3'd1;
  localparam logic [2:0] PH_PATHLEN = 3'd2;
  localparam logic [2:0] PH_PATH    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SWALLOW = 3'd5;

  logic [2:0]     phase_r, phase_nxt;
  logic [1:0]     tcnt_r, tcnt_nxt;
  logic [7:0]     tlow_r, tlow_nxt;
  logic [7:0]     path_r, path_nxt;
  logic [8:0]     pay_r, pay_nxt;
  logic [7:0]     held_r, held_nxt;
  logic           held_vld_r, held_vld_nxt;
  logic [7:0]     hdr_r, hdr_nxt;
  logic           err_r, err_nxt;
  logic [FCW-1:0] fc_r, fc_nxt;

  logic [7:0] b;
  logic       eof;
  logic [2:0] ph_e;
  logic [9:0] pay_next;
  logic [7:0] path_dec;
  logic       trim;
  logic [1:0] n;

  assign b   = item.data_byte;
  assign eof = item.end_of_frame;
  assign pay_next = {1'b0, pay_r} + 10'd1;
  assign path_dec = path_r - 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    tcnt_nxt     = tcnt_r;
    tlow_nxt     = tlow_r;
    path_nxt     = path_r;
    pay_nxt      = pay_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    hdr_nxt      = hdr_r;
    err_nxt      = err_r;
    fc_nxt       = fc_r;
    ph_e         = phase_r;
    trim         = 1'b0;
    n            = 2'd0;
    res.rec      = '0;

    // frame length guard runs ahead of the phase logic
    if (phase_r == PH_HEADER) begin
      fc_nxt = FCW'(1);
    end else begin
      if (fc_r <= FC_MAX) fc_nxt = fc_r + FCW'(1);
      if (!err_r && (fc_nxt > FC_MAX)) begin
        err_nxt      = 1'b1;
        held_vld_nxt = 1'b0;
        ph_e         = PH_SWALLOW;
        phase_nxt    = PH_SWALLOW;
      end
    end

    case (ph_e)
      PH_HEADER: begin
        hdr_nxt      = b;
        tcnt_nxt     = 2'd0;
        pay_nxt      = 9'd0;
        path_nxt     = 8'd0;
        held_vld_nxt = 1'b0;
        err_nxt      = 1'b0;
        res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_HDR, {8'd0, b}, 1'b0, 1'b0, b);
        n = n + 2'd1;
        phase_nxt = cfg.transport_route_mask[b[1:0]] ? PH_XPORT : PH_PATHLEN;
        if (eof) begin
          res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_END, 16'd0, 1'b1, 1'b1, b);
          n = n + 2'd1;
          phase_nxt = PH_HEADER;
        end
      end
      PH_XPORT: begin
        if (!tcnt_r[0]) begin
          tlow_nxt = b;
        end else begin
          res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_XPORT, {b, tlow_r}, 1'b0, 1'b0, hdr_r);
          n = n + 2'd1;
        end
        if (tcnt_r == 2'd3) begin
          tcnt_nxt  = 2'd0;
          phase_nxt = PH_PATHLEN;
        end else begin
          tcnt_nxt = tcnt_r + 2'd1;
        end
        if (eof) begin
          res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_END, 16'd0, 1'b1, 1'b1, hdr_r);
          n = n + 2'd1;
          phase_nxt    = PH_HEADER;
          err_nxt      = 1'b0;
          held_vld_nxt = 1'b0;
        end
      end
      PH_PATHLEN: begin
        res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_PATHLEN, {8'd0, b}, 1'b0, 1'b0, hdr_r);
        n = n + 2'd1;
        if (b > cfg.max_path_len) begin
          err_nxt      = 1'b1;
          held_vld_nxt = 1'b0;
          phase_nxt    = PH_SWALLOW;
          if (eof) begin
            res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_END, 16'd0, 1'b1, 1'b1, hdr_r);
            n = n + 2'd1;
            phase_nxt = PH_HEADER;
            err_nxt   = 1'b0;
          end
        end else if (eof) begin
          // zero path with nothing after it is a valid empty frame
          res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_END, 16'd0, b != 8'd0, 1'b1, hdr_r);
          n = n + 2'd1;
          phase_nxt    = PH_HEADER;
          err_nxt      = 1'b0;
          held_vld_nxt = 1'b0;
        end else begin
          path_nxt  = b;
          phase_nxt = (b != 8'd0) ? PH_PATH : PH_PAYLOAD;
        end
      end
      PH_PATH: begin
        res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_PATH, {8'd0, b}, 1'b0, 1'b0, hdr_r);
        n = n + 2'd1;
        path_nxt = path_dec;
        if (eof) begin
          res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_END, 16'd0, path_dec != 8'd0, 1'b1,
                                       hdr_r);
          n = n + 2'd1;
          phase_nxt    = PH_HEADER;
          err_nxt      = 1'b0;
          held_vld_nxt = 1'b0;
        end else if (path_dec == 8'd0) begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (pay_next > {1'b0, cfg.max_payload_len}) begin
          err_nxt      = 1'b1;
          held_vld_nxt = 1'b0;
          phase_nxt    = PH_SWALLOW;
          if (eof) begin
            res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_END, 16'd0, 1'b1, 1'b1, hdr_r);
            n = n + 2'd1;
            phase_nxt = PH_HEADER;
            err_nxt   = 1'b0;
          end
        end else begin
          trim = eof && (hdr_r[5:2] == cfg.advert_type_code) &&
                 (pay_next == mpd_pkg::ADVERT_FULL_LEN);
          if (held_vld_r) begin
            res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_PAYLOAD, {8'd0, held_r}, 1'b0, 1'b0,
                                         hdr_r);
            n = n + 2'd1;
          end
          if (eof) begin
            if (!trim) begin
              res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_PAYLOAD, {8'd0, b}, 1'b0, 1'b0,
                                           hdr_r);
              n = n + 2'd1;
            end
            res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_END,
                                         {6'd0, trim ? mpd_pkg::ADVERT_TRIM_LEN : pay_next},
                                         1'b0, 1'b1, hdr_r);
            n = n + 2'd1;
            phase_nxt    = PH_HEADER;
            err_nxt      = 1'b0;
            held_vld_nxt = 1'b0;
            pay_nxt      = 9'd0;
          end else begin
            held_nxt     = b;
            held_vld_nxt = 1'b1;
            pay_nxt      = pay_next[9] ? mpd_pkg::PAYLOAD_SAT : pay_next[8:0];
          end
        end
      end
      default: begin
        if (eof) begin
          res.rec[n] = mpd_pkg::mk_rec(mpd_pkg::KIND_END, 16'd0, 1'b1, 1'b1, hdr_r);
          n = n + 2'd1;
          phase_nxt    = PH_HEADER;
          err_nxt      = 1'b0;
          held_vld_nxt = 1'b0;
        end
      end
    endcase
    res.cnt = go ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      tcnt_r     <= 2'd0;
      tlow_r     <= 8'd0;
      path_r     <= 8'd0;
      pay_r      <= 9'd0;
      held_r     <= 8'd0;
      held_vld_r <= 1'b0;
      hdr_r      <= 8'd0;
      err_r      <= 1'b0;
      fc_r       <= '0;
    end else if (go) begin
      phase_r    <= phase_nxt;
      tcnt_r     <= tcnt_nxt;
      tlow_r     <= tlow_nxt;
      path_r     <= path_nxt;
      pay_r      <= pay_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      hdr_r      <= hdr_nxt;
      err_r      <= err_nxt;
      fc_r       <= fc_nxt;
    end
  end

endmodule

// ===== hdl/mpd_rq.sv =====
// Result queue: takes up to three records per cycle, hands out one per cycle.
// Depends on mpd_pkg.
module mpd_rq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mpd_pkg::res_t            push,
  input  logic                     pop,
  output logic                     out_vld,
  output mpd_pkg::out_t            out_data,
  output logic [mpd_pkg::RQ_AW:0]  count
);

  localparam int AW = mpd_pkg::RQ_AW;

  mpd_pkg::out_t mem [mpd_pkg::RQ_DEPTH];

  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign out_vld  = (cnt_r != '0);
  assign out_data = mem[rd_r];
  assign count    = cnt_r;
  assign cnt_nxt  = cnt_r + (AW+1)'(push.cnt) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < mpd_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < push.cnt) mem[wr_r + AW'(i)] <= push.rec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + AW'(push.cnt);
      if (pop) rd_r <= rd_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/mesh_packet_deframer_unit.sv =====
// Each accepted byte is registered; its records then pass through the result queue to
// out_*. One byte per cycle is sustained while out_stall stays low and each byte yields
// at most one record (the result queue drains one a cycle). A byte that ends a frame may
// yield up to three records; the 4-entry result queue stalls input until it has room
// for three. Swallowed bytes yield nothing. Reset (rst_n low, synchronous) empties the
// queue, returns to the header phase and loads the register defaults; no clearing pass.
module mesh_packet_deframer_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  output logic          in_stall,
  input  mpd_pkg::in_t  in_data,
  output logic          out_vld,
  input  logic          out_stall,
  output mpd_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [8:0]    cfg_wdata
);

  localparam int AW = mpd_pkg::RQ_AW;

  mpd_pkg::cfg_t cfg_r;
  mpd_pkg::in_t  item_r;
  logic          item_vld_r, item_vld_nxt;
  logic          room, go, accept, pop;
  logic [AW:0]   q_count;
  mpd_pkg::res_t res;

  assign room     = q_count <= (AW+1)'(mpd_pkg::RQ_DEPTH - mpd_pkg::MAX_RESULTS);
  assign go       = item_vld_r && room;
  assign in_stall = item_vld_r && !room;
  assign accept   = in_vld && !in_stall;
  assign pop      = out_vld && !out_stall;
  assign item_vld_nxt = accept ? 1'b1 : (go ? 1'b0 : item_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transport_route_mask <= 4'd9;
      cfg_r.max_path_len         <= 8'd64;
      cfg_r.max_payload_len      <= 9'd184;
      cfg_r.advert_type_code     <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_idx)
        mpd_pkg::CFG_XPORT_MASK: cfg_r.transport_route_mask <= cfg_wdata[3:0];
        mpd_pkg::CFG_MAX_PATH:   cfg_r.max_path_len         <= cfg_wdata[7:0];
        mpd_pkg::CFG_MAX_PAY:    cfg_r.max_payload_len      <= cfg_wdata;
        mpd_pkg::CFG_ADVERT:     cfg_r.advert_type_code     <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  mpd_step u_step (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .item (item_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  mpd_rq u_rq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res),
    .pop     (pop),
    .out_vld (out_vld),
    .out_data(out_data),
    .count   (q_count)
  );

  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= (AW+1)'(mpd_pkg::RQ_DEPTH))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res.cnt != 2'd0) |=> out_vld)
    else $error("records pushed but nothing offered");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && out_data.last) |-> (out_data.kind == mpd_pkg::KIND_END))
    else $error("last flag on a non-end record");

  a_status_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !out_data.last) |-> !out_data.status)
    else $error("status set on a non-end record");

endmodule

// ===== tb/deframe_checker.sv =====
// Record checker for mesh_packet_deframer_unit: predicts the records of every accepted
// frame byte and compares them in order with the records the block delivers.
// Depends on mpd_pkg for the channel types, record kinds and register indexes.
module deframe_checker
  import mpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  logic       in_stall,
  input  in_t        in_data,
  input  logic       out_vld,
  input  logic       out_stall,
  input  out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [8:0] cfg_wdata,
  output int         mismatches,
  output int         recs_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] MASK_DEFAULT   = 4'd9;
  localparam logic [7:0] PATH_DEFAULT   = 8'd64;
  localparam logic [8:0] PAY_DEFAULT    = 9'd184;
  localparam logic [3:0] ADVERT_DEFAULT = 4'd4;

  typedef enum logic [2:0] {
    AT_HEADER, AT_TRANSPORT, AT_PATH_LEN, AT_PATH, AT_PAYLOAD, AT_SWALLOW
  } deframe_phase_e;

  // register copies
  logic [3:0] route_mask;
  logic [7:0] path_limit;
  logic [8:0] pay_limit;
  logic [3:0] advert_code;

  // frame state
  deframe_phase_e phase;
  logic [1:0] xport_cnt;
  logic [7:0] xport_lo;
  logic [7:0] path_left;
  logic [8:0] pay_cnt;
  logic [7:0] held_byte;
  logic       held_vld;
  logic [7:0] hdr;
  logic       in_error;
  int         frame_len;

  out_t due_recs[$];

  function automatic void expect_rec(logic [2:0] kind, logic [15:0] value, logic status,
                                     logic last);
    out_t r;
    r.kind       = kind;
    r.value      = value;
    r.route_code = hdr[1:0];
    r.pay_code   = hdr[5:2];
    r.version    = hdr[7:6];
    r.status     = status;
    r.last       = last;
    due_recs.push_back(r);
  endfunction

  function automatic void close_frame(logic bad, logic [9:0] len);
    expect_rec(KIND_END, bad ? 16'h0000 : {6'h00, len}, bad, 1'b1);
    phase    = AT_HEADER;
    in_error = 1'b0;
    held_vld = 1'b0;
  endfunction

  function automatic void drop_frame();
    in_error = 1'b1;
    held_vld = 1'b0;
    phase    = AT_SWALLOW;
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic eof);
    logic [9:0] next;
    logic       trim;
    if (phase == AT_HEADER) begin
      frame_len = 1;
    end else begin
      if (frame_len <= MAX_FRAME_BYTES) frame_len++;
      if (!in_error && frame_len > MAX_FRAME_BYTES) drop_frame();
    end
    case (phase)
      AT_HEADER: begin
        hdr       = b;
        xport_cnt = '0;
        pay_cnt   = '0;
        path_left = '0;
        held_vld  = 1'b0;
        in_error  = 1'b0;
        expect_rec(KIND_HDR, {8'h00, b}, 1'b0, 1'b0);
        phase = route_mask[b[1:0]] ? AT_TRANSPORT : AT_PATH_LEN;
        if (eof) close_frame(1'b1, '0);
      end
      AT_TRANSPORT: begin
        // codes are little-endian: low byte first
        if (!xport_cnt[0]) xport_lo = b;
        else expect_rec(KIND_XPORT, {b, xport_lo}, 1'b0, 1'b0);
        if (xport_cnt == 2'd3) begin
          xport_cnt = '0;
          phase     = AT_PATH_LEN;
        end else begin
          xport_cnt++;
        end
        if (eof) close_frame(1'b1, '0);
      end
      AT_PATH_LEN: begin
        expect_rec(KIND_PATHLEN, {8'h00, b}, 1'b0, 1'b0);
        if (b > path_limit) begin
          drop_frame();
          if (eof) close_frame(1'b1, '0);
        end else if (eof) begin
          close_frame(b != 8'd0, '0);
        end else begin
          path_left = b;
          phase     = (b != 8'd0) ? AT_PATH : AT_PAYLOAD;
        end
      end
      AT_PATH: begin
        expect_rec(KIND_PATH, {8'h00, b}, 1'b0, 1'b0);
        path_left = path_left - 8'd1;
        if (eof) close_frame(path_left != 8'd0, '0);
        else if (path_left == 8'd0) phase = AT_PAYLOAD;
      end
      AT_PAYLOAD: begin
        next = {1'b0, pay_cnt} + 10'd1;
        if (next > {1'b0, pay_limit}) begin
          drop_frame();
          if (eof) close_frame(1'b1, '0);
        end else begin
          trim = eof && (hdr[5:2] == advert_code) && (next == ADVERT_FULL_LEN);
          if (held_vld) expect_rec(KIND_PAYLOAD, {8'h00, held_byte}, 1'b0, 1'b0);
          if (eof) begin
            if (!trim) expect_rec(KIND_PAYLOAD, {8'h00, b}, 1'b0, 1'b0);
            close_frame(1'b0, trim ? ADVERT_TRIM_LEN : next);
            pay_cnt = '0;
          end else begin
            held_byte = b;
            held_vld  = 1'b1;
            pay_cnt   = (next > {1'b0, PAYLOAD_SAT}) ? PAYLOAD_SAT : next[8:0];
          end
        end
      end
      default: begin
        if (eof) close_frame(1'b1, '0);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      route_mask  = MASK_DEFAULT;
      path_limit  = PATH_DEFAULT;
      pay_limit   = PAY_DEFAULT;
      advert_code = ADVERT_DEFAULT;
      phase       = AT_HEADER;
      xport_cnt   = '0;
      xport_lo    = '0;
      path_left   = '0;
      pay_cnt     = '0;
      held_byte   = '0;
      held_vld    = 1'b0;
      hdr         = '0;
      in_error    = 1'b0;
      frame_len   = 0;
      mismatches  = 0;
      due_recs.delete();
    end else begin
      if (out_vld && !out_stall) begin
        if (due_recs.size() == 0) begin
          $display("%0t: unexpected record kind=%0d value=%h status=%0d last=%0d",
                   $time, out_data.kind, out_data.value, out_data.status, out_data.last);
          mismatches++;
        end else begin
          want = due_recs.pop_front();
          if (out_data.kind !== want.kind || out_data.value !== want.value ||
              out_data.route_code !== want.route_code ||
              out_data.pay_code !== want.pay_code ||
              out_data.version !== want.version || out_data.status !== want.status ||
              out_data.last !== want.last) begin
            $display("%0t: record mismatch, expected kind=%0d value=%h rt=%0d pt=%0d ver=%0d",
                     $time, want.kind, want.value, want.route_code, want.pay_code,
                     want.version, " status=%0d last=%0d; got kind=%0d value=%h rt=%0d",
                     want.status, want.last, out_data.kind, out_data.value,
                     out_data.route_code, " pt=%0d ver=%0d status=%0d last=%0d",
                     out_data.pay_code, out_data.version, out_data.status,
                     out_data.last);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_XPORT_MASK: route_mask  = cfg_wdata[3:0];
          CFG_MAX_PATH:   path_limit  = cfg_wdata[7:0];
          CFG_MAX_PAY:    pay_limit   = cfg_wdata[8:0];
          CFG_ADVERT:     advert_code = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_vld && !in_stall) deframe_byte(in_data.data_byte, in_data.end_of_frame);
    end
    recs_due = due_recs.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the deframer testbench: clock, reset, register settings, frame stimulus and
// output back-pressure; verdict from deframe_checker's mismatches and recs_due.
// Depends on mpd_pkg, mesh_packet_deframer_unit and deframe_checker.
module testbench;
  import mpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       in_vld;
  logic       in_stall;
  in_t        in_data;
  logic       out_vld;
  logic       out_stall;
  out_t       out_data;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [8:0] cfg_wdata;
  int         mismatches;
  int         recs_due;

  // register values as last written, used to shape frames
  logic [3:0] xmask;
  logic [7:0] max_path;
  logic [8:0] max_pay;
  logic [3:0] adv_code;

  bit calm;       // no random idling on either side while set
  int hold_reqs;  // bumped to ask the receiver for a long hold-off
  int bytes_sent;

  mesh_packet_deframer_unit u_top (.*);
  deframe_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_seen) begin
        hold_left  = 40;
        holds_seen = hold_reqs;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 11);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 11) begin
      in_vld <= 1'b0;
      @(negedge clk);
    end
    in_vld  <= 1'b1;
    in_data <= in_t'{data_byte: b, end_of_frame: eof};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // header, transport codes if the route asks for them, path length, path, payload;
  // cut > 0 ends the frame after that many bytes
  task automatic send_frame(input logic [7:0] hdr, input int plen, input int npay,
                            input int cut);
    logic [7:0] fb[$];
    int n;
    fb.push_back(hdr);
    if (xmask[hdr[1:0]]) repeat (4) fb.push_back(8'($urandom_range(255)));
    fb.push_back(8'(plen));
    repeat (plen + npay) fb.push_back(8'($urandom_range(255)));
    n = (cut == 0 || cut > fb.size()) ? fb.size() : cut;
    for (int i = 0; i < n; i++) send_byte(fb[i], i == n - 1);
  endtask

  task automatic send_random_frame();
    logic [7:0] hdr;
    int pick, plen, npay, fixed, cut, n;
    hdr = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) hdr[5:2] = adv_code;
    fixed = xmask[hdr[1:0]] ? 6 : 2;
    plen  = $urandom_range(0, (max_path < 6) ? max_path : 6);
    npay  = $urandom_range(0, (max_pay < 12) ? max_pay : 12);
    cut   = 0;
    pick  = $urandom_range(99);
    if (pick < 10) begin
      cut = $urandom_range(1, fixed + plen + npay);
    end else if (pick < 18 && max_path < 8'd255) begin
      // path length over the limit, then a few swallowed bytes
      plen = $urandom_range(max_path + 1, (max_path > 251) ? 255 : max_path + 4);
      cut  = fixed + $urandom_range(0, 4);
    end else if (pick < 26 && max_pay < 9'd40) begin
      npay = max_pay + $urandom_range(1, 3);
    end
    if (pick >= 92) begin
      // noise: random bytes with random frame ends, always closed at the end
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(3) == 0));
    end else begin
      send_frame(hdr, plen, npay, cut);
    end
  endtask

  task automatic random_frames(input int nbytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) send_random_frame();
  endtask

  // drop valid, wait for every expected record, then let swallowed bytes finish
  task automatic settle();
    @(negedge clk);
    in_vld <= 1'b0;
    while (recs_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_config(input logic [3:0] mask, input logic [7:0] pth,
                             input logic [8:0] pay, input logic [3:0] adv);
    xmask    = mask;
    max_path = pth;
    max_pay  = pay;
    adv_code = adv;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_XPORT_MASK;
    cfg_wdata <= {5'd0, mask};
    @(negedge clk);
    cfg_idx   <= CFG_MAX_PATH;
    cfg_wdata <= {1'b0, pth};
    @(negedge clk);
    cfg_idx   <= CFG_MAX_PAY;
    cfg_wdata <= pay;
    @(negedge clk);
    cfg_idx   <= CFG_ADVERT;
    cfg_wdata <= {5'd0, adv};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_vld     = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    calm       = 1'b0;
    hold_reqs  = 0;
    bytes_sent = 0;
    xmask      = 4'd9;
    max_path   = 8'd64;
    max_pay    = 9'd184;
    adv_code   = 4'd4;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: routes 0 and 3 carry transport codes
    send_frame(8'hFF, 0, 0, 1);     // header only
    send_frame(8'h00, 0, 0, 3);     // ends inside the transport codes
    send_frame(8'h02, 0, 0, 0);     // zero path, no payload
    send_frame(8'h41, 65, 0, 4);    // path length over the limit
    send_frame(8'hBE, 2, 3, 0);
    send_frame(8'h01, 3, 0, 3);     // ends inside the path
    send_frame(8'h06, 1, 0, 0);     // ends right after the path
    send_frame(8'h12, 0, 107, 0);   // advert of 107 bytes: trimmed
    hold_reqs++;
    send_frame(8'h92, 2, 20, 0);    // sent into the hold-off
    settle();

    load_config(4'd0, 8'd0, 9'd0, 4'd0);
    send_frame(8'h03, 0, 1, 0);     // any payload is too long
    random_frames(15);
    settle();

    calm = 1'b1;
    load_config(4'($urandom_range(15)), 8'($urandom_range(8)), 9'($urandom_range(16)),
                4'($urandom_range(15)));
    random_frames(15);
    settle();
    calm = 1'b0;

    load_config(4'($urandom_range(15)), 8'($urandom_range(8)), 9'($urandom_range(16)),
                4'($urandom_range(15)));
    random_frames(10);
    hold_reqs++;
    random_frames(10);
    settle();

    load_config(4'($urandom_range(15)), 8'($urandom_range(255)), 9'($urandom_range(511)),
                4'($urandom_range(15)));
    random_frames(12);
    settle();

    if (mismatches == 0 && recs_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
